// ===== sv/lbd_restart_decider_assert.svh =====
// Assertion helpers for the restart decider checker.
`ifndef LBD_RESTART_DECIDER_ASSERT_SVH
`define LBD_RESTART_DECIDER_ASSERT_SVH

// Concurrent assertion, aborted while reset is high.
`define LRD_ASSERT(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define LRD_ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== sv/lrd_pkg.sv =====
`default_nettype none
package lrd_pkg;

  localparam int LBD_WINDOW   = 50;
  localparam int STACK_WINDOW = 5000;

  localparam int MODE_W  = 2;
  localparam int LBD_W   = 16;
  localparam int SSIZE_W = 20;
  localparam int COUNT_W = 32;
  localparam int TOTAL_W = 48;
  localparam int CFG_W   = 32;

  localparam int LBD_HEAD_W   = $clog2(LBD_WINDOW);
  localparam int LBD_FILL_W   = $clog2(LBD_WINDOW + 1);
  localparam int LBD_SUM_W    = $clog2(longint'(LBD_WINDOW) << LBD_W);
  localparam int STACK_HEAD_W = $clog2(STACK_WINDOW);
  localparam int STACK_FILL_W = $clog2(STACK_WINDOW + 1);
  localparam int STACK_SUM_W  = $clog2(longint'(STACK_WINDOW) << SSIZE_W);

  // restart: sum * 4 * count > total * 5 * window
  localparam int LBD_SCALE   = 5 * LBD_WINDOW;
  localparam int LBD_SCALE_W = $clog2(LBD_SCALE + 1);
  localparam int LBD_LHS_W   = LBD_SUM_W + 2 + COUNT_W;
  localparam int LBD_RHS_W   = TOTAL_W + LBD_SCALE_W;
  localparam int LBD_CMP_W   = (LBD_LHS_W > LBD_RHS_W) ? LBD_LHS_W : LBD_RHS_W;

  // blocking: stack_sum * 6 < stack_size * 5 * stack_fill
  localparam int STK_LHS_W = STACK_SUM_W + 3;
  localparam int STK_RHS_W = SSIZE_W + 3 + STACK_FILL_W;
  localparam int STK_CMP_W = (STK_LHS_W > STK_RHS_W) ? STK_LHS_W : STK_RHS_W;

  localparam logic [CFG_W-1:0] BLOCK_MIN_RESET = CFG_W'(10000);

  typedef enum logic [MODE_W-1:0] {
    MODE_LEARN     = 2'd0,
    MODE_CHECK     = 2'd1,
    MODE_RESTARTED = 2'd2,
    MODE_IGNORE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EVAL,
    PH_COMMIT
  } phase_t;

  typedef struct packed {
    mode_t              mode;
    logic [LBD_W-1:0]   lbd;
    logic [SSIZE_W-1:0] ssize;
  } item_t;

  typedef struct packed {
    logic [LBD_HEAD_W-1:0]   lbd_head;
    logic [LBD_FILL_W-1:0]   lbd_fill;
    logic [LBD_SUM_W-1:0]    lbd_sum;
    logic [STACK_HEAD_W-1:0] stack_head;
    logic [STACK_FILL_W-1:0] stack_fill;
    logic [STACK_SUM_W-1:0]  stack_sum;
    logic [TOTAL_W-1:0]      total;
    logic [COUNT_W-1:0]      count;
  } state_t;

  typedef struct packed {
    logic block;
    logic restart;
  } decide_t;

endpackage
`default_nettype wire

// ===== sv/lrd_chan_if.sv =====
`default_nettype none
interface lrd_in_if import lrd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [LBD_W-1:0]   lbd;
  logic [SSIZE_W-1:0] stack_size;

  modport source (output valid, mode, lbd, stack_size, input ready);
  modport sink   (input valid, mode, lbd, stack_size, output ready);
endinterface

interface lrd_out_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, restart, input ready);
  modport sink   (input valid, restart, output ready);
endinterface
`default_nettype wire

// ===== sv/lrd_ram.sv =====
`default_nettype none
module lrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/lrd_score.sv =====
`default_nettype none
module lrd_score import lrd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire state_t             st,
  input  wire logic [SSIZE_W-1:0] ssize,
  input  wire logic [CFG_W-1:0]   block_min,
  output decide_t                 dec
);

  logic [LBD_SUM_W+COUNT_W-1:0]     lbd_prod;
  logic [LBD_RHS_W-1:0]             total_prod;
  logic [SSIZE_W+2:0]               ssize5;
  logic [STK_RHS_W-1:0]             stk_prod;

  logic [LBD_CMP_W-1:0] lbd_lhs;
  logic [LBD_CMP_W-1:0] lbd_rhs;
  logic [STK_CMP_W-1:0] stk_lhs;
  logic [STK_CMP_W-1:0] stk_rhs;
  logic                 over_min;
  logic                 full;

  assign lbd_prod   = st.lbd_sum * st.count;
  assign total_prod = st.total * LBD_SCALE_W'(LBD_SCALE);
  assign ssize5     = {ssize, 2'b00} + (SSIZE_W+3)'(ssize);
  assign stk_prod   = ssize5 * st.stack_fill;

  always_ff @(posedge clk) begin
    if (load) begin
      lbd_lhs  <= LBD_CMP_W'({lbd_prod, 2'b00});
      lbd_rhs  <= LBD_CMP_W'(total_prod);
      stk_lhs  <= STK_CMP_W'({st.stack_sum, 2'b00}) + STK_CMP_W'({st.stack_sum, 1'b0});
      stk_rhs  <= STK_CMP_W'(stk_prod);
      over_min <= st.count > block_min;
      full     <= st.lbd_fill == LBD_FILL_W'(LBD_WINDOW);
    end
  end

  // a block clears the window, so no restart can follow it
  always_comb begin
    dec.block   = over_min && full && (stk_lhs < stk_rhs);
    dec.restart = !dec.block && full && (lbd_lhs > lbd_rhs);
  end

endmodule
`default_nettype wire

// ===== sv/lrd_state.sv =====
`default_nettype none
module lrd_state import lrd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               commit,
  input  wire item_t              itm,
  input  wire logic [LBD_W-1:0]   lbd_old,
  input  wire logic [SSIZE_W-1:0] stack_old,
  input  wire decide_t            dec,
  output state_t                  st,
  output state_t                  st_next
);

  logic                 lbd_full;
  logic                 stack_full;
  logic [TOTAL_W:0]     total_sum;

  assign lbd_full   = st.lbd_fill == LBD_FILL_W'(LBD_WINDOW);
  assign stack_full = st.stack_fill == STACK_FILL_W'(STACK_WINDOW);
  assign total_sum  = {1'b0, st.total} + (TOTAL_W+1)'(itm.lbd);

  always_comb begin
    st_next = st;
    if (commit) begin
      unique case (itm.mode)
        MODE_LEARN: begin
          if (lbd_full) begin
            st_next.lbd_sum = st.lbd_sum + LBD_SUM_W'(itm.lbd) - LBD_SUM_W'(lbd_old);
          end else begin
            st_next.lbd_fill = st.lbd_fill + 1'b1;
            st_next.lbd_sum  = st.lbd_sum + LBD_SUM_W'(itm.lbd);
          end
          st_next.lbd_head = (st.lbd_head == LBD_HEAD_W'(LBD_WINDOW - 1)) ?
                             '0 : st.lbd_head + 1'b1;
          if (stack_full) begin
            st_next.stack_sum = st.stack_sum + STACK_SUM_W'(itm.ssize)
                                - STACK_SUM_W'(stack_old);
          end else begin
            st_next.stack_fill = st.stack_fill + 1'b1;
            st_next.stack_sum  = st.stack_sum + STACK_SUM_W'(itm.ssize);
          end
          st_next.stack_head = (st.stack_head == STACK_HEAD_W'(STACK_WINDOW - 1)) ?
                               '0 : st.stack_head + 1'b1;
          st_next.total = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          if (st.count != '1) begin
            st_next.count = st.count + 1'b1;
          end
        end
        MODE_CHECK: begin
          if (dec.block) begin
            st_next.lbd_head = '0;
            st_next.lbd_fill = '0;
            st_next.lbd_sum  = '0;
          end
        end
        MODE_RESTARTED: begin
          st_next.lbd_head = '0;
          st_next.lbd_fill = '0;
          st_next.lbd_sum  = '0;
        end
        MODE_IGNORE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lbd_restart_decider.sv =====
// channel  | dir | handshake    | payload
// item     | in  | valid/ready  | mode[1:0], lbd[15:0], stack_size[19:0]
// result   | out | valid/ready  | restart
// cfg      | in  | cfg_we       | cfg_data[31:0] (block_min_conflicts)
//
// The window RAM read issued at accept returns in the eval cycle, where the
// cross products are registered; the commit cycle compares, updates the state
// and writes the RAMs; the result is registered at commit. A stalled result
// holds the commit; a new item is taken in the commit cycle. Reset is
// synchronous; the window RAMs need no clearing.
`default_nettype none
module lbd_restart_decider import lrd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  lrd_in_if.sink                item,
  lrd_out_if.source             result,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data
);

  phase_t               ph;
  phase_t               ph_next;
  item_t                itm;
  state_t               st;
  state_t               st_next;
  decide_t              dec;
  logic [CFG_W-1:0]     block_min;
  logic [LBD_W-1:0]     lbd_old;
  logic [SSIZE_W-1:0]   stack_old;
  logic                 acc;
  logic                 out_free;
  logic                 commit;
  logic                 eval_en;
  logic                 learn_we;

  assign acc      = item.valid && item.ready;
  assign out_free = !result.valid || result.ready;
  assign learn_we = commit && (itm.mode == MODE_LEARN);

  always_comb begin
    ph_next = ph;
    unique case (ph)
      PH_IDLE:   if (item.valid) ph_next = PH_EVAL;
      PH_EVAL:   ph_next = PH_COMMIT;
      PH_COMMIT: begin
        if (out_free) begin
          ph_next = item.valid ? PH_EVAL : PH_IDLE;
        end
      end
      default:   ph_next = PH_IDLE;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    commit     = 1'b0;
    eval_en    = 1'b0;
    unique case (ph)
      PH_IDLE:   item.ready = 1'b1;
      PH_EVAL:   eval_en = 1'b1;
      PH_COMMIT: begin
        commit     = out_free;
        item.ready = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE;
    end else begin
      ph <= ph_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      itm.mode  <= mode_t'(item.mode);
      itm.lbd   <= item.lbd;
      itm.ssize <= item.stack_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_min <= BLOCK_MIN_RESET;
    end else if (cfg_we) begin
      block_min <= cfg_data;
    end
  end

  // read address follows the commit happening at the same edge
  lrd_ram #(.WIDTH(LBD_W), .DEPTH(LBD_WINDOW)) u_lbd_ram (
    .clk   (clk),
    .we    (learn_we),
    .waddr (st.lbd_head),
    .wdata (itm.lbd),
    .re    (acc),
    .raddr (st_next.lbd_head),
    .rdata (lbd_old)
  );

  lrd_ram #(.WIDTH(SSIZE_W), .DEPTH(STACK_WINDOW)) u_stack_ram (
    .clk   (clk),
    .we    (learn_we),
    .waddr (st.stack_head),
    .wdata (itm.ssize),
    .re    (acc),
    .raddr (st_next.stack_head),
    .rdata (stack_old)
  );

  lrd_score u_score (
    .clk       (clk),
    .load      (eval_en),
    .st        (st),
    .ssize     (itm.ssize),
    .block_min (block_min),
    .dec       (dec)
  );

  lrd_state u_state (
    .clk       (clk),
    .rst       (rst),
    .commit    (commit),
    .itm       (itm),
    .lbd_old   (lbd_old),
    .stack_old (stack_old),
    .dec       (dec),
    .st        (st),
    .st_next   (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.restart <= dec.restart && (itm.mode == MODE_CHECK);
    end
  end

endmodule
`default_nettype wire

// ===== sv/lrd_checker.sv =====
`default_nettype none
`include "lbd_restart_decider_assert.svh"
module lrd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic item_valid,
  input wire logic item_ready,
  input wire logic result_valid,
  input wire logic result_ready,
  input wire logic result_restart
);

  logic item_acc;

  assign item_acc = item_valid && item_ready;

  `LRD_ASSERT(a_one_in_flight, clk, rst, item_acc |=> !item_ready, "second transaction taken early")
  `LRD_ASSERT(a_result_follows, clk, rst, item_acc |-> ##3 result_valid, "result missing")
  `LRD_ASSERT(a_result_hold, clk, rst, (result_valid && !result_ready) |=> (result_valid && $stable(result_restart)), "stalled result changed")
  `LRD_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !result_valid, "result valid after reset")

endmodule

bind lbd_restart_decider lrd_checker u_lrd_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_restart (result.restart)
);
`default_nettype wire

// ===== dv/lbd_restart_decider_tb.sv =====
`timescale 1ns / 1ps
module lbd_restart_decider_tb;
  import lrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 135;
  localparam bit [63:0] TOTAL_MAX = 64'hFFFF_FFFF_FFFF;
  localparam bit [63:0] COUNT_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    mode_t              mode;
    logic [LBD_W-1:0]   lbd;
    logic [SSIZE_W-1:0] ssize;
    logic               restart;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  lrd_in_if  item_ch ();
  lrd_out_if result_ch ();

  lbd_restart_decider i_dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // shadow of the decider state
  bit [CFG_W-1:0]   block_min;
  bit [LBD_W-1:0]   lbd_win [LBD_WINDOW];
  int unsigned      lbd_head, lbd_fill;
  bit [63:0]        lbd_sum;
  bit [SSIZE_W-1:0] stack_win [STACK_WINDOW];
  int unsigned      stack_head, stack_fill;
  bit [63:0]        stack_sum;
  bit [63:0]        grand_total;
  bit [63:0]        conflicts;
  bit               last_restart;

  bit restart_expected [$];
  bit want_restart;

  int unsigned mismatches, results_checked, cycles;
  int unsigned n_learn, n_check, n_restarts, n_blocked, n_settings;
  int lbd_level, stack_level;

  dir_row_t directed_rows [18] = '{
    '{MODE_CHECK,     16'h0000, 20'h00000, 1'b0},  // no conflicts yet
    '{MODE_RESTARTED, 16'h0000, 20'h00000, 1'b0},
    '{MODE_IGNORE,    16'hFFFF, 20'hFFFFF, 1'b0},
    '{MODE_LEARN,     16'h0000, 20'h00000, 1'b0},
    '{MODE_LEARN,     16'hFFFF, 20'hFFFFF, 1'b0},
    '{MODE_CHECK,     16'h0000, 20'hFFFFF, 1'b0},
    '{MODE_LEARN,     16'h0001, 20'h00064, 1'b0},
    '{MODE_LEARN,     16'h0007, 20'h000C8, 1'b0},
    '{MODE_LEARN,     16'h8000, 20'h12345, 1'b0},
    '{MODE_CHECK,     16'hFFFF, 20'h00000, 1'b0},
    '{MODE_RESTARTED, 16'hFFFF, 20'hFFFFF, 1'b0},
    '{MODE_LEARN,     16'h0003, 20'h00005, 1'b0},
    '{MODE_IGNORE,    16'h0000, 20'h00000, 1'b0},
    '{MODE_IGNORE,    16'h5555, 20'hAAAAA, 1'b0},
    '{MODE_CHECK,     16'hAAAA, 20'h55555, 1'b0},
    '{MODE_LEARN,     16'hAAAA, 20'h55555, 1'b0},
    '{MODE_LEARN,     16'h5555, 20'hAAAAA, 1'b0},
    '{MODE_CHECK,     16'h0000, 20'hFFFFF, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles,
               restart_expected.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void clear_lbd_window();
    lbd_head = 0;
    lbd_fill = 0;
    lbd_sum  = '0;
  endfunction

  function automatic bit predict_restart(mode_t m, bit [LBD_W-1:0] l, bit [SSIZE_W-1:0] s);
    bit r;
    r = 1'b0;
    case (m)
      MODE_LEARN: begin
        n_learn++;
        if (lbd_fill == LBD_WINDOW) lbd_sum -= lbd_win[lbd_head];
        else lbd_fill++;
        lbd_win[lbd_head] = l;
        lbd_sum += l;
        lbd_head = (lbd_head + 1) % LBD_WINDOW;
        if (stack_fill == STACK_WINDOW) stack_sum -= stack_win[stack_head];
        else stack_fill++;
        stack_win[stack_head] = s;
        stack_sum += s;
        stack_head = (stack_head + 1) % STACK_WINDOW;
        if (TOTAL_MAX - grand_total < 64'(l)) grand_total = TOTAL_MAX;
        else grand_total += l;
        if (conflicts < COUNT_MAX) conflicts++;
      end
      MODE_CHECK: begin
        n_check++;
        if (conflicts > 64'(block_min) && lbd_fill == LBD_WINDOW && stack_fill != 0 &&
            stack_sum * 6 < 64'(s) * 5 * 64'(stack_fill)) begin
          clear_lbd_window();
          n_blocked++;
        end
        if (lbd_fill == LBD_WINDOW &&
            lbd_sum * 4 * conflicts > grand_total * 5 * 64'(LBD_WINDOW)) begin
          r = 1'b1;
          n_restarts++;
        end
        last_restart = r;
      end
      MODE_RESTARTED: begin
        clear_lbd_window();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic got, logic want);
    mismatches++;
    $display("MISMATCH at %0t: %s (got %b, want %b)", $realtime, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (restart_expected.size() == 0) begin
        flag_mismatch("result transaction with nothing pending", result_ch.restart, 1'b0);
      end else begin
        want_restart = restart_expected.pop_front();
        results_checked++;
        if (result_ch.restart !== want_restart)
          flag_mismatch("restart", result_ch.restart, want_restart);
      end
    end
  end

  // receiver stall pattern, switching among randomly chosen styles
  initial begin
    int style;
    int n;
    result_ch.ready <= 1'b0;
    n = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (n % 48 == 0) style = $urandom_range(0, 3);
      case (style)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'($urandom_range(0, 1));
        2: result_ch.ready <= ($urandom_range(0, 3) == 0);
        default: result_ch.ready <= (n % 3 == 0);
      endcase
      n++;
    end
  end

  task automatic send_item(mode_t m, bit [LBD_W-1:0] l, bit [SSIZE_W-1:0] s,
                           bit typed, bit typed_restart);
    bit r;
    item_ch.valid      <= 1'b1;
    item_ch.mode       <= m;
    item_ch.lbd        <= l;
    item_ch.stack_size <= s;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    r = predict_restart(m, l, s);
    restart_expected.push_back(typed ? typed_restart : r);
  endtask

  task automatic idle_gap(int unsigned n);
    item_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (restart_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_block_min(bit [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    block_min = v;
    n_settings++;
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned done_items, burst;
    int r, lv, st;
    mode_t m;
    done_items = 0;
    burst = $urandom_range(1, 12);
    while (done_items < n_items) begin
      r = $urandom_range(0, 99);
      if (last_restart) begin
        last_restart = 1'b0;
        m = ($urandom_range(0, 3) != 0) ? MODE_RESTARTED : MODE_CHECK;
      end else if (r < 64) begin
        m = MODE_LEARN;
      end else if (r < 95) begin
        m = MODE_CHECK;
      end else if (r < 97) begin
        m = MODE_RESTARTED;
      end else begin
        m = MODE_IGNORE;
      end

      if ($urandom_range(0, 39) == 0)
        lbd_level = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 60000)
                                                : $urandom_range(1, 12);
      if ($urandom_range(0, 49) == 0) stack_level = $urandom_range(10, 900000);

      case ($urandom_range(0, 49))
        0: lv = 0;
        1: lv = 16'hFFFF;
        2: lv = $urandom_range(0, 16'hFFFF);
        default: lv = lbd_level + $urandom_range(0, 3);
      endcase

      r = $urandom_range(0, 19);
      if (r == 0) st = 0;
      else if (r == 1) st = 20'hFFFFF;
      else if (r == 2) st = $urandom_range(0, 20'hFFFFF);
      else if (m == MODE_CHECK && r < 10) st = stack_level * 3 / 2 + $urandom_range(0, 1000);
      else st = stack_level + $urandom_range(0, stack_level / 8);
      if (st > 20'hFFFFF) st = 20'hFFFFF;

      send_item(m, LBD_W'(lv), SSIZE_W'(st), 1'b0, 1'b0);
      if (m != MODE_IGNORE) done_items++;

      burst--;
      if (burst == 0) begin
        idle_gap($urandom_range(1, 6));
        burst = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    bit [CFG_W-1:0] settings [6];
    settings = '{32'd0, 32'hFFFF_FFFF, 32'd40, 32'd120, 32'd0, 32'd10000};
    settings[4] = $urandom_range(0, 300);

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.mode       <= MODE_LEARN;
    item_ch.lbd        <= '0;
    item_ch.stack_size <= '0;

    block_min   = BLOCK_MIN_RESET;
    clear_lbd_window();
    stack_head  = 0;
    stack_fill  = 0;
    stack_sum   = '0;
    grand_total = '0;
    conflicts   = '0;
    lbd_level   = 4;
    stack_level = 1000;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run under the reset threshold
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].mode, directed_rows[i].lbd, directed_rows[i].ssize,
                1'b1, directed_rows[i].restart);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
    end
    drain();

    foreach (settings[i]) begin
      write_block_min(settings[i]);
      run_random(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Ran %0d learned clauses and %0d checks across %0d threshold settings",
             n_learn, n_check, n_settings);
    $display("%0d results checked: %0d restart decisions, %0d blocked checks",
             results_checked, n_restarts, n_blocked);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
